@@ hw/rtl/sha256_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// -----------------------------------------------------------------------------
package sha256_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} core_state_t;

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

endpackage

@@ hw/rtl/sha256_front.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_front
// Short queue that decouples the byte stream from the core.
// -----------------------------------------------------------------------------
module sha256_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha256_pkg::item_t   in_item,
	output logic                q_valid,
	input  logic                q_take,
	output sha256_pkg::item_t   q_item
);
	import sha256_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	item_t          mem_q [QUEUE_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;
	logic           push;
	logic           pop;

	// idle items carry nothing; drop them here
	assign in_stall = (cnt_q == AW'(0) + (AW+1)'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall && (in_item.byte_valid || in_item.end_of_message);
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid && q_take;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop)  rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ hw/rtl/sha256_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_core
// Byte packing, padding, 64-round compression and digest output.
// -----------------------------------------------------------------------------
module sha256_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  sha256_pkg::item_t  q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_number,
	output logic               final_word
);
	import sha256_pkg::*;

	core_state_t  state_q, state_d;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [60:0]  count_q;
	logic [31:0]  asm_q;
	logic [5:0]   fill_q;
	logic [5:0]   rnd_q;
	logic [3:0]   pad_q;     // length bytes emitted, 0..8
	logic         pad_mode_q;
	logic         spill_q;   // 0x80 landed in bytes 56..62: length goes in the next block
	logic         eom_q;     // end of message still pending after a compression
	logic [2:0]   emit_q;
	logic         ov_q;

	logic         byte_go;
	logic [7:0]   byte_in;
	logic [63:0]  bits;
	logic [31:0]  wnew, wcur, t1, t2;

	assign bits = {count_q, 3'b000};
	assign wnew = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign wcur = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : wnew;
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[rnd_q] + wcur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign out_valid   = ov_q;
	assign digest_word = h_q[emit_q];
	assign word_number = emit_q;
	assign final_word  = (emit_q == 3'd7);

	always_comb begin
		state_d = state_q;
		q_take  = 1'b0;
		byte_go = 1'b0;
		byte_in = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_take  = 1'b1;
					byte_go = q_item.byte_valid;
					byte_in = q_item.data_byte;
					if (q_item.byte_valid && fill_q == 6'd63) state_d = ST_ROUND;
					else if (q_item.end_of_message) state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				byte_go = 1'b1;
				if (!pad_mode_q) byte_in = 8'h80;
				else if (fill_q < 6'd56 || spill_q) byte_in = 8'h00;
				else byte_in = bits[63 - 8*fill_q[2:0] -: 8];
				if (fill_q == 6'd63) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63) state_d = ST_ADD;
			end
			ST_ADD: begin
				if (!eom_q) state_d = ST_IDLE;
				else if (pad_q == 4'd8) state_d = ST_EMIT;
				else state_d = ST_PAD;
			end
			ST_EMIT: begin
				if (!out_stall && emit_q == 3'd7) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (byte_go) begin
			if (fill_q[1:0] == 2'd3) w_q[fill_q[5:2]] <= {asm_q[23:0], byte_in};
		end else if (state_q == ST_ROUND && rnd_q >= 6'd16) begin
			// slide window: newest word at index 15
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end else if (state_q == ST_ROUND && rnd_q == 6'd15) begin
			// hold window: w_q[0] is already W[r-16] for the next round
			for (int i = 0; i < 16; i++) w_q[i] <= w_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= init_hash(3'(i));
				v_q[i] <= '0;
			end
			count_q    <= '0;
			asm_q      <= '0;
			fill_q     <= '0;
			rnd_q      <= '0;
			pad_q      <= '0;
			pad_mode_q <= 1'b0;
			spill_q    <= 1'b0;
			eom_q      <= 1'b0;
			emit_q     <= '0;
			ov_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (byte_go) begin
				asm_q  <= (fill_q[1:0] == 2'd3) ? 32'h0 : {asm_q[23:0], byte_in};
				fill_q <= fill_q + 6'd1;
				if (state_q == ST_PAD) pad_mode_q <= 1'b1;
				if (state_q == ST_IDLE && !(&count_q)) count_q <= count_q + 61'd1;
			end
			if (state_q == ST_PAD) begin
				if (!pad_mode_q) spill_q <= (fill_q >= 6'd56) && (fill_q != 6'd63);
				else if (fill_q == 6'd63) spill_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						eom_q <= q_item.end_of_message;
						if (byte_go && fill_q == 6'd63) begin
							rnd_q   <= '0;
							for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						end else if (q_item.end_of_message) begin
							pad_mode_q <= 1'b0;
						end
					end
				end
				ST_PAD: begin
					if (fill_q == 6'd63) begin
						rnd_q   <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					end
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 6'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (eom_q && pad_q == 4'd8) begin
						emit_q  <= '0;
						ov_q    <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							ov_q    <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
							count_q    <= '0;
							asm_q      <= '0;
							fill_q     <= '0;
							pad_q      <= '0;
							pad_mode_q <= 1'b0;
							eom_q      <= 1'b0;
						end
					end
				end
				default: ;
			endcase
			if (state_q == ST_PAD && pad_mode_q && !spill_q && fill_q >= 6'd56)
				pad_q <= pad_q + 4'd1;
		end
	end
endmodule

@@ hw/rtl/sha256_hasher_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_hasher_unit
// Streaming SHA-256 over a byte stream.
// -----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with data_byte, byte_valid, end_of_message.
// One message byte per word; end_of_message marks the last word of a message
// (with byte_valid low it closes the message without adding a byte). Words
// with neither flag set are dropped at the input.
// Output channel: out_valid/out_stall with digest_word, word_number and
// final_word; eight words per message, H0 first, final_word on the eighth.
// A four-entry queue sits between the input and the hashing core, so input
// is still accepted while the core compresses a block, until the queue fills.
// Throughput: the core takes one byte per cycle while it is idle and the queue
// holds a byte; it takes none while a 64-byte block runs the round loop (one
// round per cycle) and the chain update. Closing a message pads byte by byte,
// runs one or two more compressions, then shows the digest.
// Output stall holds the current digest word; the core then waits.
// Reset loads the initial hash values and clears counts and queue.
// -----------------------------------------------------------------------------
module sha256_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word
);
	import sha256_pkg::*;

	item_t in_item, q_item;
	logic  q_valid, q_take;

	assign in_item = '{data_byte: data_byte, byte_valid: byte_valid,
		end_of_message: end_of_message};

	sha256_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.q_valid, .q_take, .q_item
	);

	sha256_core u_core (
		.clk, .arst_n, .q_valid, .q_take, .q_item,
		.out_valid, .out_stall, .digest_word, .word_number, .final_word
	);
endmodule

@@ hw/rtl/sha256_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sha256_checker
// Port-level checks for the SHA-256 hasher.
// -----------------------------------------------------------------------------
module sha256_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_number,
	input logic        final_word
);
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_word == (word_number == 3'd7)))
		else $error("final_word mismatch");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word) && $stable(word_number))
		else $error("stalled word changed");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !final_word |=> out_valid &&
		word_number == $past(word_number) + 3'd1)
		else $error("digest words out of order");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && final_word |=> !out_valid)
		else $error("output after final word");
endmodule

bind sha256_hasher_unit sha256_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .digest_word, .word_number, .final_word
);

@@ tb/sv/tb_sha256_hasher_unit.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_sha256_hasher_unit
// Drives byte streams into the hasher with random input gaps and output stalls.
// A digest model in the scoreboard predicts the eight words of each message and
// checks them in order as they leave the block.
// -----------------------------------------------------------------------------

class digest_board;
	bit [31:0] hash_st [8];
	bit [31:0] sched [16];
	bit [31:0] acc_word;
	bit [60:0] msg_bytes;
	int unsigned fill;
	bit [31:0] digest_q [$];
	bit [2:0] index_q [$];
	bit last_q [$];
	int errors;

	function new();
		errors = 0;
		restart();
	endfunction

	function void restart();
		hash_st = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		msg_bytes = '0;
		acc_word = '0;
		fill = 0;
	endfunction

	function bit [31:0] ror(bit [31:0] v, int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	function void compress();
		bit [31:0] v [8];
		bit [31:0] w, t1, t2, s0, s1;
		v = hash_st;
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				w = sched[r];
			end else begin
				s1 = sched[(r - 2) & 15];
				s0 = sched[(r - 15) & 15];
				w = (ror(s1, 17) ^ ror(s1, 19) ^ (s1 >> 10)) + sched[(r - 7) & 15]
					+ (ror(s0, 7) ^ ror(s0, 18) ^ (s0 >> 3)) + sched[r & 15];
				sched[r & 15] = w;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[r] + w;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_st[i] += v[i];
	endfunction

	function void absorb(bit [7:0] b);
		acc_word = {acc_word[23:0], b};
		fill++;
		if ((fill & 3) == 0) begin
			sched[((fill - 1) >> 2) & 15] = acc_word;
			acc_word = '0;
		end
		if (fill >= 64) begin
			compress();
			fill = 0;
		end
	endfunction

	// note one accepted input word
	function void note_input(bit [7:0] b, bit bv, bit eom);
		bit [63:0] bits;
		if (bv) begin
			absorb(b);
			if (msg_bytes != '1) msg_bytes++;
		end
		if (!eom) return;
		bits = {msg_bytes, 3'b000};
		absorb(8'h80);
		while (fill != 56) absorb(8'h00);
		for (int i = 0; i < 8; i++) absorb(bits[63 - 8 * i -: 8]);
		for (int i = 0; i < 8; i++) begin
			digest_q.push_back(hash_st[i]);
			index_q.push_back(3'(i));
			last_q.push_back(i == 7);
		end
		restart();
	endfunction

	function void report(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endfunction

	function void check_output(bit [31:0] d, bit [2:0] n, bit f);
		bit [31:0] ed;
		bit [2:0] en;
		bit ef;
		if (digest_q.size() == 0) begin
			report($sformatf("unexpected digest word %h", d));
			return;
		end
		ed = digest_q.pop_front();
		en = index_q.pop_front();
		ef = last_q.pop_front();
		if (d !== ed) report($sformatf("digest_word %h, want %h", d, ed));
		if (n !== en) report($sformatf("word_number %0d, want %0d", n, en));
		if (f !== ef) report($sformatf("final_word %0b, want %0b", f, ef));
	endfunction
endclass

module tb_sha256_hasher_unit;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic byte_valid = 1'b0;
	logic end_of_message = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0] word_number;
	logic final_word;

	digest_board board = new();
	bit calm = 1'b0;
	bit send_done = 1'b0;
	int sent = 0;

	sha256_hasher_unit uut (.*);

	always #5 clk = ~clk;

	initial begin
		#50_000_000;
		$display("tb_sha256_hasher_unit: done, errors");
		$finish;
	end

	// output side: random stall bursts, check on each accepted word
	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_output(digest_word, word_number, final_word);
			if (hold > 0) begin
				hold--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 18);
			end
			out_stall <= (hold > 0);
		end
	end

	// send one word; note it in the model once accepted
	task automatic send_word(bit [7:0] b, bit bv, bit eom);
		int gap;
		if (!calm && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_valid <= bv;
		end_of_message <= eom;
		do @(posedge clk); while (in_stall);
		board.note_input(b, bv, eom);
		if (bv || eom) sent++;
	endtask

	task automatic send_message(int len, bit empty_close, int mode);
		bit [7:0] b;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: b = 8'h00;
				1: b = 8'hff;
				default: b = 8'($urandom);
			endcase
			if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
			send_word(b, 1'b1, (i == len - 1) && !empty_close);
		end
		if (empty_close || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty message, single bytes, extremes, padding edges
		send_message(0, 1'b1, 2);
		send_message(1, 1'b0, 0);
		send_message(1, 1'b0, 1);
		send_message(3, 1'b0, 2);
		send_message(55, 1'b0, 1);
		send_message(56, 1'b1, 0);
		send_message(64, 1'b0, 2);
		// random: mostly short messages, a few spanning blocks
		while (sent < 470) begin
			if (sent > 400) calm = 1'b1;
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 130) :
				$urandom_range(0, 12);
			send_message(len, $urandom_range(0, 3) == 0, 2);
		end
		in_valid <= 1'b0;
		send_done = 1'b1;
	end

	initial begin
		wait (send_done);
		while (board.digest_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb_sha256_hasher_unit: done, clean");
		end else begin
			$display("tb_sha256_hasher_unit: done, errors");
		end
		$finish;
	end
endmodule
